@@ rtl/sst_pkg.sv @@
package sst_pkg;

  localparam int SST_FIFO_DEPTH = 4;

  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  localparam logic [15:0] LINE_FIRST = 16'd1;
  localparam logic [15:0] LINE_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_STRING  = 3'd2,
    KIND_NUMBER  = 3'd3,
    KIND_PUNCT   = 3'd4,
    KIND_EOF     = 3'd5
  } kind_t;

  // One token result without its line number.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       has;
    logic       start;
    logic       fin;
  } res_t;

  // All results caused by one input byte; both share one line number.
  typedef struct packed {
    res_t        r0;
    res_t        r1;
    logic        two;
    logic [15:0] line;
  } run_t;

endpackage

@@ rtl/sst_front.sv @@
module sst_front
  import sst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       end_of_input,
  output logic       wr_en,
  output run_t       wr_data
);

  typedef enum logic [3:0] {
    ST_START      = 4'd0,
    ST_IDENT      = 4'd1,
    ST_STR_SQ     = 4'd2,
    ST_STR_DQ     = 4'd3,
    ST_NUMBER     = 4'd4,
    ST_SLASH      = 4'd5,
    ST_BLOCK      = 4'd6,
    ST_LINE       = 4'd7,
    ST_BLOCK_STAR = 4'd8
  } state_t;

  typedef struct packed {
    logic   emit;
    res_t   res;
    state_t st;
    logic   bump;
    logic   clr_esc;
  } fs_t;

  state_t      st_r, st_nxt;
  logic        esc_r, esc_nxt;
  logic [15:0] line_r, line_nxt;

  function automatic res_t mk(kind_t k, logic [7:0] ch, logic has, logic s, logic e);
    res_t r;
    r.kind  = k;
    r.ch    = has ? ch : 8'd0;
    r.has   = has;
    r.start = s;
    r.fin   = e;
    return r;
  endfunction

  function automatic logic is_up(logic [7:0] c);
    return (c >= "A") && (c <= "Z");
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // Classification of a byte seen in the start state.
  function automatic fs_t from_start(logic [7:0] b, logic [7:0] c);
    fs_t f;
    f.emit    = 1'b0;
    f.res     = mk(KIND_UNKNOWN, 8'd0, 1'b0, 1'b0, 1'b0);
    f.st      = ST_START;
    f.bump    = 1'b0;
    f.clr_esc = 1'b0;
    if (c inside {" ", CH_CR, CH_TAB}) begin
    end else if (c == CH_LF) begin
      f.bump = 1'b1;
    end else if (c inside {"{", "}", "&", "|", "*", ";", "=", "(", ")", ","}) begin
      f.emit = 1'b1;
      f.res  = mk(KIND_PUNCT, c, 1'b1, 1'b1, 1'b1);
    end else if (c == "/") begin
      f.st = ST_SLASH;
    end else if (is_up(c) || c == "_") begin
      f.st   = ST_IDENT;
      f.emit = 1'b1;
      f.res  = mk(KIND_IDENT, b, 1'b1, 1'b1, 1'b0);
    end else if (c == "+" || c == "-" || is_dig(c)) begin
      f.st   = ST_NUMBER;
      f.emit = 1'b1;
      f.res  = mk(KIND_NUMBER, c, 1'b1, 1'b1, 1'b0);
    end else if (c == "'" || c == "\"") begin
      f.st      = (c == "'") ? ST_STR_SQ : ST_STR_DQ;
      f.clr_esc = 1'b1;
      f.emit    = 1'b1;
      f.res     = mk(KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b0);
    end else begin
      f.emit = 1'b1;
      f.res  = mk(KIND_UNKNOWN, c, 1'b1, 1'b1, 1'b1);
    end
    return f;
  endfunction

  logic [7:0] c;
  fs_t        fs;
  logic       emit_a, emit_b, bump;
  res_t       res_a, res_b;

  assign c  = (byte_in >= "a" && byte_in <= "z") ? byte_in - 8'd32 : byte_in;
  assign fs = from_start(byte_in, c);

  always_comb begin
    st_nxt  = st_r;
    esc_nxt = esc_r;
    bump    = 1'b0;
    emit_a  = 1'b0;
    emit_b  = 1'b0;
    res_a   = mk(KIND_UNKNOWN, 8'd0, 1'b0, 1'b0, 1'b0);
    res_b   = res_a;
    if (end_of_input) begin
      emit_a = 1'b1;
      res_a  = mk(KIND_EOF, 8'd0, 1'b0, 1'b1, 1'b1);
    end else begin
      case (st_r)
        ST_SLASH: begin
          if (c == "*") begin
            st_nxt = ST_BLOCK;
          end else if (c == "/") begin
            st_nxt = ST_LINE;
          end else begin
            emit_a = 1'b1;
            res_a  = mk(KIND_UNKNOWN, "/", 1'b1, 1'b1, 1'b1);
            emit_b = fs.emit;
            res_b  = fs.res;
            st_nxt = fs.st;
            bump   = fs.bump;
            if (fs.clr_esc) esc_nxt = 1'b0;
          end
        end
        ST_BLOCK: begin
          if (c == "*") st_nxt = ST_BLOCK_STAR;
          else if (c == CH_LF) bump = 1'b1;
        end
        ST_BLOCK_STAR: begin
          if (c == "/") begin
            st_nxt = ST_START;
          end else if (c != "*") begin
            st_nxt = ST_BLOCK;
            bump   = (c == CH_LF);
          end
        end
        ST_LINE: begin
          if (c == CH_LF) begin
            st_nxt = ST_START;
            bump   = 1'b1;
          end
        end
        ST_IDENT, ST_NUMBER: begin
          if (st_r == ST_IDENT && (is_up(c) || is_dig(c) || c == "_")) begin
            emit_a = 1'b1;
            res_a  = mk(KIND_IDENT, byte_in, 1'b1, 1'b0, 1'b0);
          end else if (st_r == ST_NUMBER && (is_dig(c) || c == "+" || c == "-")) begin
            emit_a = 1'b1;
            res_a  = mk(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0);
          end else begin
            // The terminating byte closes the token and is then rescanned.
            emit_a = 1'b1;
            res_a  = mk((st_r == ST_IDENT) ? KIND_IDENT : KIND_NUMBER,
                        8'd0, 1'b0, 1'b0, 1'b1);
            emit_b = fs.emit;
            res_b  = fs.res;
            st_nxt = fs.st;
            bump   = fs.bump;
            if (fs.clr_esc) esc_nxt = 1'b0;
          end
        end
        ST_STR_SQ, ST_STR_DQ: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
            emit_a  = 1'b1;
            res_a   = mk(KIND_STRING, byte_in, 1'b1, 1'b0, 1'b0);
          end else if ((st_r == ST_STR_SQ && c == "'") ||
                       (st_r == ST_STR_DQ && c == "\"")) begin
            emit_a = 1'b1;
            res_a  = mk(KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b1);
            st_nxt = ST_START;
          end else if (c == "\\") begin
            esc_nxt = 1'b1;
          end else begin
            emit_a = 1'b1;
            res_a  = mk(KIND_STRING, byte_in, 1'b1, 1'b0, 1'b0);
          end
        end
        default: begin
          emit_a = fs.emit;
          res_a  = fs.res;
          st_nxt = fs.st;
          bump   = fs.bump;
          if (fs.clr_esc) esc_nxt = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (end_of_input) line_nxt = LINE_FIRST;
    else if (bump && line_r != LINE_MAX) line_nxt = line_r + 16'd1;
    else line_nxt = line_r;
  end

  assign wr_en        = accept && emit_a;
  assign wr_data.r0   = res_a;
  assign wr_data.r1   = res_b;
  assign wr_data.two  = emit_b;
  assign wr_data.line = line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_START;
      esc_r  <= 1'b0;
      line_r <= LINE_FIRST;
    end else if (accept) begin
      st_r   <= end_of_input ? ST_START : st_nxt;
      esc_r  <= end_of_input ? 1'b0 : esc_nxt;
      line_r <= line_nxt;
    end
  end

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 16'd0) else $error("line counter reached zero");

  a_eof_reset: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_input |=> st_r == ST_START && !esc_r && line_r == LINE_FIRST)
    else $error("scanner not returned to start after end of input");

endmodule

@@ rtl/sst_fifo.sv @@
module sst_fifo
  import sst_pkg::*;
#(
  parameter int DEPTH = SST_FIFO_DEPTH
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  run_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output run_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= inc(wr_ptr_r);
      if (do_rd) rd_ptr_r <= inc(rd_ptr_r);
      if (do_wr && !do_rd) count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count beyond depth");

endmodule

@@ rtl/sst_back.sv @@
module sst_back
  import sst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_valid,
  input  run_t        rd_data,
  output logic        rd_en,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  token_kind,
  output logic [7:0]  char_code,
  output logic        has_char,
  output logic        token_start,
  output logic        token_end,
  output logic [15:0] line_number,
  output logic        last_of_run
);

  run_t run_r;
  logic valid_r, idx_r;
  logic take, finish;
  res_t cur;

  assign take   = pop && valid_r;
  assign finish = take && (idx_r || !run_r.two);
  assign rd_en  = rd_valid && (!valid_r || finish);
  assign cur    = idx_r ? run_r.r1 : run_r.r0;

  assign empty       = !valid_r;
  assign token_kind  = cur.kind;
  assign char_code   = cur.ch;
  assign has_char    = cur.has;
  assign token_start = cur.start;
  assign token_end   = cur.fin;
  assign line_number = run_r.line;
  assign last_of_run = idx_r || !run_r.two;

  always_ff @(posedge clk) begin
    if (rd_en) run_r <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else if (rd_en) begin
      valid_r <= 1'b1;
      idx_r   <= 1'b0;
    end else if (finish) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else if (take) begin
      idx_r <= 1'b1;
    end
  end

  a_second_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && idx_r |-> run_r.two) else $error("second result of a single run");

  a_split_advance: assert property (@(posedge clk) disable iff (!rst_n)
    take && !idx_r && run_r.two |=> valid_r && idx_r)
    else $error("second result of a run lost");

endmodule

@@ rtl/script_source_tokenizer.sv @@
// Channel   Handshake          Fields
// input     push / full        in_byte_in, in_end_of_input
// result    empty / pop        out_token_kind, out_char_code, out_has_char,
//                              out_token_start, out_token_end, out_line_number,
//                              out_last_of_run
//
// A byte is scanned in the cycle it is accepted; one byte a cycle is taken
// while the run queue has room. Each byte yields zero, one or two results,
// and the output stage hands out one result a cycle while pop is held high;
// the first result of a byte passes through the run queue and the output
// register before it can be popped. Synchronous active-low reset clears the
// scanner, the queue and the output stage. A stalled result side fills the
// queue and then raises full; the scanner keeps its state meanwhile.
module script_source_tokenizer
  import sst_pkg::*;
#(
  parameter int FIFO_DEPTH = SST_FIFO_DEPTH
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_in,
  input  logic        in_end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_token_kind,
  output logic [7:0]  out_char_code,
  output logic        out_has_char,
  output logic        out_token_start,
  output logic        out_token_end,
  output logic [15:0] out_line_number,
  output logic        out_last_of_run
);

  logic accept, wr_en, rd_en, rd_valid;
  run_t wr_data, rd_data;

  assign accept = push && !full;

  sst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .byte_in      (in_byte_in),
    .end_of_input (in_end_of_input),
    .wr_en        (wr_en),
    .wr_data      (wr_data)
  );

  sst_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .full     (full),
    .rd_en    (rd_en),
    .rd_valid (rd_valid),
    .rd_data  (rd_data)
  );

  sst_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_valid    (rd_valid),
    .rd_data     (rd_data),
    .rd_en       (rd_en),
    .empty       (empty),
    .pop         (pop),
    .token_kind  (out_token_kind),
    .char_code   (out_char_code),
    .has_char    (out_has_char),
    .token_start (out_token_start),
    .token_end   (out_token_end),
    .line_number (out_line_number),
    .last_of_run (out_last_of_run)
  );

endmodule

@@ test/script_source_tokenizer_tb.sv @@
import sst_pkg::*;

typedef enum logic [3:0] {
  SC_START,
  SC_IDENT,
  SC_STR_SQ,
  SC_STR_DQ,
  SC_NUMBER,
  SC_SLASH,
  SC_BLOCK,
  SC_LINE,
  SC_BLOCK_STAR
} scan_t;

typedef struct packed {
  kind_t       kind;
  logic [7:0]  ch;
  logic        has;
  logic        start;
  logic        fin;
  logic [15:0] line_no;
  logic        last;
} tok_t;

localparam string PUNCT_CHARS = "{}&|*;=(),";

class tok_scoreboard;
  scan_t       scan;
  logic        escaped;
  logic [15:0] line_no;
  tok_t        run_q[$];
  tok_t        expected_q[$];
  int unsigned mismatches;

  function new();
    restart();
    mismatches = 0;
  endfunction

  function void restart();
    scan    = SC_START;
    escaped = 1'b0;
    line_no = LINE_FIRST;
  endfunction

  function void bump_line();
    if (line_no != LINE_MAX) line_no++;
  endfunction

  function bit is_upper(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function bit is_punct(logic [7:0] c);
    for (int i = 0; i < PUNCT_CHARS.len(); i++) begin
      if (c == PUNCT_CHARS[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function void add(kind_t kind, logic [7:0] ch, logic has, logic start, logic fin);
    tok_t t;
    t.kind    = kind;
    t.ch      = has ? ch : 8'd0;
    t.has     = has;
    t.start   = start;
    t.fin     = fin;
    t.line_no = line_no;
    t.last    = 1'b0;
    run_q.push_back(t);
  endfunction

  // Classification from the idle state; b is the raw byte, c the folded one.
  function void from_start(logic [7:0] b, logic [7:0] c);
    if (c == " " || c == CH_CR || c == CH_TAB) begin
      // Blanks produce nothing.
    end else if (c == CH_LF) begin
      bump_line();
    end else if (is_punct(c)) begin
      add(KIND_PUNCT, c, 1'b1, 1'b1, 1'b1);
    end else if (c == "/") begin
      scan = SC_SLASH;
    end else if (is_upper(c) || c == "_") begin
      scan = SC_IDENT;
      add(KIND_IDENT, b, 1'b1, 1'b1, 1'b0);
    end else if (c == "+" || c == "-" || is_digit(c)) begin
      scan = SC_NUMBER;
      add(KIND_NUMBER, c, 1'b1, 1'b1, 1'b0);
    end else if (c == "'" || c == "\"") begin
      scan    = (c == "'") ? SC_STR_SQ : SC_STR_DQ;
      escaped = 1'b0;
      add(KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b0);
    end else begin
      add(KIND_UNKNOWN, c, 1'b1, 1'b1, 1'b1);
    end
  endfunction

  // Predicts the results of one accepted request and returns how many there are.
  function int note_request(logic [7:0] b, logic eoi);
    logic [7:0] c;
    c = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    run_q.delete();
    if (eoi) begin
      add(KIND_EOF, 8'd0, 1'b0, 1'b1, 1'b1);
      restart();
    end else begin
      case (scan)
        SC_START: from_start(b, c);
        SC_SLASH: begin
          if (c == "*") begin
            scan = SC_BLOCK;
          end else if (c == "/") begin
            scan = SC_LINE;
          end else begin
            add(KIND_UNKNOWN, "/", 1'b1, 1'b1, 1'b1);
            scan = SC_START;
            from_start(b, c);
          end
        end
        SC_BLOCK: begin
          if (c == "*") scan = SC_BLOCK_STAR;
          else if (c == CH_LF) bump_line();
        end
        SC_BLOCK_STAR: begin
          if (c == "/") begin
            scan = SC_START;
          end else if (c != "*") begin
            scan = SC_BLOCK;
            if (c == CH_LF) bump_line();
          end
        end
        SC_LINE: begin
          if (c == CH_LF) begin
            scan = SC_START;
            bump_line();
          end
        end
        SC_IDENT: begin
          if (is_upper(c) || is_digit(c) || c == "_") begin
            add(KIND_IDENT, b, 1'b1, 1'b0, 1'b0);
          end else begin
            add(KIND_IDENT, 8'd0, 1'b0, 1'b0, 1'b1);
            scan = SC_START;
            from_start(b, c);
          end
        end
        SC_NUMBER: begin
          if (is_digit(c) || c == "+" || c == "-") begin
            add(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0);
          end else begin
            add(KIND_NUMBER, 8'd0, 1'b0, 1'b0, 1'b1);
            scan = SC_START;
            from_start(b, c);
          end
        end
        SC_STR_SQ, SC_STR_DQ: begin
          if (escaped) begin
            escaped = 1'b0;
            add(KIND_STRING, b, 1'b1, 1'b0, 1'b0);
          end else if ((scan == SC_STR_SQ && c == "'") || (scan == SC_STR_DQ && c == "\"")) begin
            add(KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b1);
            scan = SC_START;
          end else if (c == "\\") begin
            escaped = 1'b1;
          end else begin
            add(KIND_STRING, b, 1'b1, 1'b0, 1'b0);
          end
        end
        default: begin
          scan = SC_START;
          from_start(b, c);
        end
      endcase
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) expected_q.push_back(run_q[i]);
    return run_q.size();
  endfunction

  function string show(tok_t t);
    return $sformatf("kind %0d char %02h has %b start %b end %b line %0d last %b",
                     t.kind, t.ch, t.has, t.start, t.fin, t.line_no, t.last);
  endfunction

  function void check_result(tok_t got);
    tok_t want;
    if (expected_q.size() == 0) begin
      if (mismatches < 10) $display("ERROR: result with nothing expected: %s", show(got));
      mismatches++;
    end else begin
      want = expected_q.pop_front();
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("ERROR: token result differs at %0t", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
        mismatches++;
      end
    end
  endfunction
endclass

module script_source_tokenizer_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  in_byte_in = 8'd0;
  logic        in_end_of_input = 1'b0;
  logic        full;
  logic        empty;
  logic [2:0]  out_token_kind;
  logic [7:0]  out_char_code;
  logic        out_has_char;
  logic        out_token_start;
  logic        out_token_end;
  logic [15:0] out_line_number;
  logic        out_last_of_run;

  tok_scoreboard sb = new();

  bit          sender_idles = 1'b0;
  bit          receiver_stalls = 1'b0;
  bit          want_long_hold = 1'b0;
  int unsigned requests_sent = 0;

  script_source_tokenizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_byte_in      (in_byte_in),
    .in_end_of_input (in_end_of_input),
    .empty           (empty),
    .pop             (pop),
    .out_token_kind  (out_token_kind),
    .out_char_code   (out_char_code),
    .out_has_char    (out_has_char),
    .out_token_start (out_token_start),
    .out_token_end   (out_token_end),
    .out_line_number (out_line_number),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one request and returns once it has been accepted. Push stays high
  // between back-to-back requests.
  task automatic send_request(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push            <= 1'b1;
    in_byte_in      <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (full) @(posedge clk);
    void'(sb.note_request(b, eoi));
    requests_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  function automatic logic [7:0] word_char(input bit lead);
    int unsigned r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  // Mostly well-formed lexical pieces with random content, plus noise and
  // end-of-input markers that can land in the middle of anything.
  task automatic send_random_fragment();
    logic [7:0]  frag[$];
    logic [7:0]  q;
    logic [7:0]  b;
    int unsigned r;
    int unsigned k;
    int unsigned len;
    bit          eoi;
    eoi = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      frag.push_back(word_char(1'b1));
      len = $urandom_range(0, 5);
      repeat (len) frag.push_back(word_char(1'b0));
    end else if (r < 35) begin
      len = $urandom_range(1, 5);
      repeat (len) begin
        k = $urandom_range(0, 11);
        frag.push_back(k == 10 ? "+" : k == 11 ? "-" : 8'("0" + k));
      end
    end else if (r < 53) begin
      q = $urandom_range(0, 1) ? "'" : "\"";
      frag.push_back(q);
      len = $urandom_range(0, 6);
      repeat (len) begin
        b = 8'($urandom_range(0, 255));
        if (b == q || b == "\\" || $urandom_range(0, 7) == 0) frag.push_back("\\");
        frag.push_back(b);
      end
      frag.push_back(q);
    end else if (r < 65) begin
      frag.push_back(PUNCT_CHARS[$urandom_range(0, 9)]);
    end else if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       frag.push_back(" ");
        1:       frag.push_back(CH_TAB);
        2:       frag.push_back(CH_CR);
        default: frag.push_back(CH_LF);
      endcase
    end else if (r < 82) begin
      frag.push_back("/");
      frag.push_back("*");
      len = $urandom_range(0, 5);
      repeat (len) begin
        case ($urandom_range(0, 5))
          0, 1:    frag.push_back("*");
          2:       frag.push_back(CH_LF);
          default: frag.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      frag.push_back("*");
      frag.push_back("/");
    end else if (r < 87) begin
      frag.push_back("/");
      frag.push_back("/");
      len = $urandom_range(0, 6);
      repeat (len) begin
        b = 8'($urandom_range(0, 255));
        frag.push_back(b == CH_LF ? 8'h0B : b);
      end
      frag.push_back(CH_LF);
    end else if (r < 91) begin
      frag.push_back("/");
    end else if (r < 98) begin
      frag.push_back(8'($urandom_range(0, 255)));
    end else begin
      eoi = 1'b1;
    end
    foreach (frag[i]) send_request(frag[i], 1'b0);
    if (eoi) send_request(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Result side: checks every accepted result and stalls in bursts, or for a
  // long stretch when asked so that the block backs up into its input.
  initial begin
    tok_t        got;
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got.kind    = kind_t'(out_token_kind);
        got.ch      = out_char_code;
        got.has     = out_has_char;
        got.start   = out_token_start;
        got.fin     = out_token_end;
        got.line_no = out_line_number;
        got.last    = out_last_of_run;
        sb.check_result(got);
      end
      if (want_long_hold) begin
        want_long_hold = 1'b0;
        hold = 150;
      end
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 7) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned frags;
    bit [1:0]    mode;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    // Identifier ended by punctuation, number ended by a letter, escaped quote,
    // empty string, comment closed by a run of stars, lone slash, line comment.
    send_text("_a9,+1z\"\\\"\"''/***//=//q\n");
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(CH_TAB, 1'b0);
    send_request(CH_CR, 1'b0);
    send_request("b", 1'b0);
    // End of input in the middle of an identifier.
    send_request(8'hA5, 1'b1);

    frags = 0;
    while (requests_sent < 1700) begin
      if (frags % 40 == 0) begin
        mode            = 2'($urandom_range(0, 3));
        sender_idles    = mode[0];
        receiver_stalls = mode[1];
      end
      if (frags == 300) want_long_hold = 1'b1;
      send_random_fragment();
      frags++;
    end

    // Last part without idling: a run of line feeds and a few short tokens.
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    send_request(8'h00, 1'b1);
    repeat (40) send_request(CH_LF, 1'b0);
    send_text("a;\n7");
    send_request(8'h00, 1'b1);
    send_text("z,");
    push <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sst_pkg.sv
rtl/sst_front.sv
rtl/sst_fifo.sv
rtl/sst_back.sv
rtl/script_source_tokenizer.sv
test/script_source_tokenizer_tb.sv
